FILE: hdl/spq_pkg.sv
// Shared types, command and status codes for the stable priority queue.
package spq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int CMD_W = 2;
	localparam int ID_W = 16;
	localparam int URG_W = 4;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;

	localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0] entry_id;
		logic [URG_W-1:0] urgency;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0] head_id;
		logic [URG_W-1:0] head_urgency;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [URG_W-1:0] urgency;
	} slot_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		slot_t slot;
		logic valid;
		logic keep;
	} link_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic insert;
		logic remove;
		slot_t item;
	} op_t;

endpackage

FILE: hdl/spq_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface spq_stream_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/spq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module spq_cell (
	input logic clk,
	input logic arst_n,
	input spq_pkg::op_t op,
	input spq_pkg::link_t prev,
	input spq_pkg::link_t next,
	output spq_pkg::link_t self
);

	spq_pkg::slot_t slot_q;
	logic valid_q;
	logic keep;

	// Entries of equal or lower number stay ahead of the new one.
	assign keep = valid_q && (slot_q.urgency <= op.item.urgency);

	assign self = {slot_q, valid_q, keep};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.insert && !keep) begin
			valid_q <= prev.keep ? 1'b1 : prev.valid;
		end else if (op.remove) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.insert && !keep) begin
			// Take the new entry at the boundary, shift back behind it.
			slot_q <= prev.keep ? op.item : prev.slot;
		end else if (op.remove) begin
			slot_q <= next.slot;
		end
	end

endmodule

FILE: hdl/stable_priority_queue.sv
// Stable priority queue: a row of sorting cells with a registered result.
//
// Channels: req carries commands (enqueue, dequeue, peek head) with an entry
// identifier and urgency; rsp returns one result per command with status,
// the head entry where it applies, and the occupancy after the command.
// Entries leave by ascending urgency, equal urgencies in arrival order.
//
// Every cell compares its urgency against the incoming one in parallel and
// either holds, takes the new entry, or takes its neighbor's entry, so a
// command finishes in the cycle it is accepted. The result is registered in the
// output register and shown in the cycle after acceptance; one command per
// cycle is sustained while rsp is ready.
//
// When rsp stalls, the result is held and req.ready drops until it is taken.
// Reset clears all slot valid bits, the count and the output valid flag;
// the queue is empty and ready in the first cycle after reset.
module stable_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	spq_stream_if.sink req,
	spq_stream_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	spq_pkg::link_t links [DEPTH];
	spq_pkg::link_t prev_links [DEPTH];
	spq_pkg::link_t next_links [DEPTH];
	spq_pkg::op_t op;
	spq_pkg::req_t cmd_in;
	spq_pkg::rsp_t rsp_d;
	spq_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic accept;
	logic full;
	logic empty;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	assign cmd_in = req.data;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = !links[0].valid;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				prev_links[i] = '0;
				prev_links[i].keep = 1'b1;
			end else begin
				prev_links[i] = links[i-1];
			end
			if (i == DEPTH - 1) begin
				next_links[i] = '0;
			end else begin
				next_links[i] = links[i+1];
			end
		end
	end

	always_comb begin
		op.insert = 1'b0;
		op.remove = 1'b0;
		op.item.id = cmd_in.entry_id;
		op.item.urgency = cmd_in.urgency;
		rsp_d = '0;
		cnt_d = cnt_q;
		case (cmd_in.cmd)
			spq_pkg::CMD_ENQ: begin
				if (full) begin
					rsp_d.status = spq_pkg::STATUS_FULL;
				end else begin
					op.insert = accept;
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
				if (empty) begin
					rsp_d.status = spq_pkg::STATUS_EMPTY;
				end else begin
					rsp_d.head_id = links[0].slot.id;
					rsp_d.head_urgency = links[0].slot.urgency;
					if (cmd_in.cmd == spq_pkg::CMD_DEQ) begin
						op.remove = accept;
						cnt_d = cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
				// Unused code: no change, report occupancy as is.
			end
		endcase
		rsp_d.occupancy = spq_pkg::OCC_W'(cnt_d);
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		spq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.op(op),
			.prev(prev_links[g]),
			.next(next_links[g]),
			.self(links[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

endmodule
